>>> hw/rtl/cid_pkg.sv
package cid_pkg;

    // Image geometry and fixed-point format
    localparam int IMAGE_SIZE    = 128;
    localparam int FRACTION_BITS = 8;

    // Field widths of the transaction payloads
    localparam int POS_W    = 15;
    localparam int DENS_W   = 16;
    localparam int RC_W     = 7;
    localparam int STATUS_W = 2;
    localparam int PIXEL_W  = 32;

    // Derived widths
    localparam int DEPTH   = IMAGE_SIZE * IMAGE_SIZE;
    localparam int COORD_W = $clog2(IMAGE_SIZE);
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CELL_W  = POS_W + 1 - FRACTION_BITS;
    localparam int WGT_W   = FRACTION_BITS + 1;
    localparam int MULA_W  = DENS_W + WGT_W;
    localparam int PROD_W  = MULA_W + WGT_W;

    typedef enum logic [0:0] {
        OP_DEPOSIT = 1'b0,
        OP_READ    = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DEPOSITED = 2'd0,
        ST_REJECTED  = 2'd1,
        ST_SATURATED = 2'd2,
        ST_READ_DONE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_RD,
        S_RDW,
        S_REJ
    } t_state;

endpackage

>>> hw/rtl/cid_in_if.sv
interface cid_in_if;
    import cid_pkg::*;

    logic                valid;
    logic                ready;
    logic [0:0]          opcode;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [DENS_W-1:0]   deposit_density;
    logic [RC_W-1:0]     read_column;
    logic [RC_W-1:0]     read_row;

    modport source (
        output valid, opcode, pos_x, pos_y, deposit_density, read_column, read_row,
        input  ready
    );

    modport sink (
        input  valid, opcode, pos_x, pos_y, deposit_density, read_column, read_row,
        output ready
    );

endinterface

>>> hw/rtl/cid_out_if.sv
interface cid_out_if;
    import cid_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PIXEL_W-1:0]  pixel_value;

    modport source (
        output valid, status, pixel_value,
        input  ready
    );

    modport sink (
        input  valid, status, pixel_value,
        output ready
    );

endinterface

>>> hw/rtl/cid_ram.sv
module cid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port: write, or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cic_image_deposit.sv
// Cloud-in-cell image accumulator.
// Input channel i_in: a transaction with opcode deposit spreads deposit_density
// bilinearly over four pixels around (pos_x, pos_y); opcode read returns pixel
// (read_column, read_row) and clears it. Output channel o_out carries one
// result transaction per input: status and pixel_value.
// A deposit runs three steps per pixel on the shared multiplier and the single
// image memory port (weight multiply with pixel read, second weight multiply,
// add-write), four pixels in turn, before its result is emitted.
// A read issues the address, then takes the registered read data and clears
// the pixel; a rejected item goes straight to its result. The block takes a
// new transaction only when idle. After reset the image memory is cleared one
// pixel a cycle, all 16384 of them (IMAGE_SIZE squared); i_in.ready stays low.
// The result sits in an output register; while the receiver stalls, the block
// may accept and work the next transaction but holds in its last step until
// the output register frees up.
module cic_image_deposit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cid_in_if.sink       i_in,
    cid_out_if.source    o_out
);
    import cid_pkg::*;

    localparam logic [FRACTION_BITS-1:0] HALF = FRACTION_BITS'(1) << (FRACTION_BITS - 1);
    localparam logic [WGT_W-1:0]         ONE  = WGT_W'(1) << FRACTION_BITS;
    localparam logic [PROD_W-1:0]        RND  = PROD_W'(1) << (2 * FRACTION_BITS - 1);
    localparam logic [COORD_W-1:0]       LAST = COORD_W'(IMAGE_SIZE - 1);

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row);
        pix_addr = ADDR_W'(col) + ADDR_W'(ADDR_W'(row) * ADDR_W'(IMAGE_SIZE));
    endfunction

    t_state r_state, n_state;

    logic [ADDR_W-1:0]  r_clr;
    logic [COORD_W-1:0] r_col_a, r_col_b, r_row_a, r_row_b;
    logic [WGT_W-1:0]   r_wx0, r_wx1, r_wy0, r_wy1;
    logic [DENS_W-1:0]  r_dens;
    logic [1:0]         r_k;
    logic               r_sat;
    logic [PROD_W-1:0]  r_prod;
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [PIXEL_W-1:0] r_pixel;

    logic               accept;
    logic               out_free;
    logic               emit;
    t_status            emit_status;
    logic [PIXEL_W-1:0] emit_pixel;

    // Position decode
    logic [POS_W:0]     sum_x, sum_y;
    logic [CELL_W-1:0]  cx, cy;
    logic               dep_reject, rd_reject;
    logic [COORD_W-1:0] base_i, base_j;

    // Shared multiplier and accumulate path
    logic [MULA_W-1:0]  mul_a;
    logic [WGT_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  rnd_p;
    logic [PIXEL_W:0]   acc_sum;
    logic               acc_sat;
    logic [COORD_W-1:0] cur_col, cur_row;
    logic [WGT_W-1:0]   cur_wx, cur_wy;

    // Memory port
    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [PIXEL_W-1:0] ram_wdata, ram_rdata;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Decode the deposit position into base cell and weights
    assign sum_x  = {1'b0, i_in.pos_x} + (POS_W + 1)'(HALF);
    assign sum_y  = {1'b0, i_in.pos_y} + (POS_W + 1)'(HALF);
    assign cx     = sum_x[POS_W:FRACTION_BITS];
    assign cy     = sum_y[POS_W:FRACTION_BITS];
    assign base_i = COORD_W'(cx - CELL_W'(1));
    assign base_j = COORD_W'(cy - CELL_W'(1));
    assign dep_reject = (cx == '0) || (cy == '0) ||
                        (32'(cx) > 32'(IMAGE_SIZE)) || (32'(cy) > 32'(IMAGE_SIZE));
    assign rd_reject  = (32'(i_in.read_column) >= 32'(IMAGE_SIZE)) ||
                        (32'(i_in.read_row) >= 32'(IMAGE_SIZE));

    // Select the pixel and weights of the current share
    assign cur_col = r_k[0] ? r_col_b : r_col_a;
    assign cur_row = r_k[1] ? r_row_b : r_row_a;
    assign cur_wx  = r_k[0] ? r_wx1 : r_wx0;
    assign cur_wy  = r_k[1] ? r_wy1 : r_wy0;

    assign mul_a = (r_state == S_MUL1) ? MULA_W'(r_dens) : r_prod[MULA_W-1:0];
    assign mul_b = (r_state == S_MUL1) ? cur_wx : cur_wy;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Round the share and add it to the pixel with saturation
    assign rnd_p   = r_prod + RND;
    assign acc_sum = {1'b0, ram_rdata} + (PIXEL_W + 1)'(rnd_p[PROD_W-1:2*FRACTION_BITS]);
    assign acc_sat = acc_sum[PIXEL_W];

    cid_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_image (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence next state, memory port and result
    always_comb begin
        n_state     = r_state;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = pix_addr(cur_col, cur_row);
        ram_wdata   = '0;
        emit        = 1'b0;
        emit_status = ST_DEPOSITED;
        emit_pixel  = '0;
        i_in.ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.opcode == OP_READ) begin
                        n_state = rd_reject ? S_REJ : S_RD;
                    end else begin
                        n_state = dep_reject ? S_REJ : S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                ram_re  = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                ram_wdata = acc_sat ? '1 : acc_sum[PIXEL_W-1:0];
                if (r_k != 2'd3) begin
                    ram_we  = 1'b1;
                    n_state = S_MUL1;
                end else if (out_free) begin
                    ram_we      = 1'b1;
                    emit        = 1'b1;
                    emit_status = (r_sat || acc_sat) ? ST_SATURATED : ST_DEPOSITED;
                    n_state     = S_IDLE;
                end
            end
            S_RD: begin
                ram_re   = 1'b1;
                ram_addr = pix_addr(r_col_a, r_row_a);
                n_state  = S_RDW;
            end
            S_RDW: begin
                ram_addr = pix_addr(r_col_a, r_row_a);
                if (out_free) begin
                    ram_we      = 1'b1;
                    emit        = 1'b1;
                    emit_status = ST_READ_DONE;
                    emit_pixel  = ram_rdata;
                    n_state     = S_IDLE;
                end
            end
            S_REJ: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = ST_REJECTED;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= r_clr + ADDR_W'(1);
        end
    end

    // Capture the transaction and work the shares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= '0;
            r_sat <= 1'b0;
        end else begin
            if (accept) begin
                r_k   <= '0;
                r_sat <= 1'b0;
            end else if (r_state == S_ACC && r_k != 2'd3) begin
                r_k   <= r_k + 2'd1;
                r_sat <= r_sat || acc_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dens <= i_in.deposit_density;
            r_wx0  <= ONE - WGT_W'(sum_x[FRACTION_BITS-1:0]);
            r_wx1  <= WGT_W'(sum_x[FRACTION_BITS-1:0]);
            r_wy0  <= ONE - WGT_W'(sum_y[FRACTION_BITS-1:0]);
            r_wy1  <= WGT_W'(sum_y[FRACTION_BITS-1:0]);
            if (i_in.opcode == OP_READ) begin
                r_col_a <= COORD_W'(i_in.read_column);
                r_row_a <= COORD_W'(i_in.read_row);
            end else begin
                r_col_a <= base_i;
                r_row_a <= base_j;
            end
            r_col_b <= (base_i == LAST) ? base_i : base_i + COORD_W'(1);
            r_row_b <= (base_j == LAST) ? base_j : base_j + COORD_W'(1);
        end
        if (r_state == S_MUL1 || r_state == S_MUL2) begin
            r_prod <= mul_p;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= emit_status;
            r_pixel  <= emit_pixel;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.pixel_value = r_pixel;

endmodule
